// ----- hdl/quadratic_root_solver_top_assert.svh -----
// assertion macros for the quadratic root solver checker
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// implication in the same cycle, quiet while reset is low
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, also watched across reset
`define QRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/qrs_pkg.sv -----
// types, sizes and helper functions shared by the quadratic root solver
package qrs_pkg;

    localparam int C_COEFF_WIDTH = 32;
    localparam int C_FRAC_BITS   = 16;
    localparam int C_EPS_WIDTH   = 48;

    localparam int C_MAG_W    = C_COEFF_WIDTH;
    localparam int C_PROD_W   = 2 * C_COEFF_WIDTH;
    localparam int C_PROD_X_W = C_PROD_W + 2;
    localparam int C_D_W      = 2 * C_COEFF_WIDTH + 1;
    localparam int C_NUM_W    = C_COEFF_WIDTH + 2 * C_FRAC_BITS;
    localparam int C_DVS_W    = C_COEFF_WIDTH + 2;
    localparam int C_DIV_T_W  = C_DVS_W + 1;
    localparam int C_SQ_IN    = (C_NUM_W > C_D_W) ? C_NUM_W : C_D_W;
    localparam int C_SQ_N     = (C_SQ_IN + 1) / 2;
    localparam int C_SQ_RAD_W = 2 * C_SQ_N;
    localparam int C_SQ_REM_W = C_SQ_N + 2;
    localparam int C_SQ_T_W   = C_SQ_REM_W + 2;
    localparam int C_CMP_W    = (C_D_W > C_EPS_WIDTH) ? C_D_W : C_EPS_WIDTH;

    typedef enum logic [1:0] {
        KIND_FIN  = 2'd0,
        KIND_NAN  = 2'd1,
        KIND_PINF = 2'd2,
        KIND_MINF = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CASE_C0,
        CASE_B0,
        CASE_GEN
    } t_case;

    typedef struct packed {
        logic signed [C_COEFF_WIDTH-1:0] coeff_a;
        logic signed [C_COEFF_WIDTH-1:0] coeff_b;
        logic signed [C_COEFF_WIDTH-1:0] coeff_c;
    } t_coeffs;

    typedef struct packed {
        logic signed [C_COEFF_WIDTH-1:0] root_one;
        t_kind                           root_one_kind;
        logic signed [C_COEFF_WIDTH-1:0] root_two;
        t_kind                           root_two_kind;
        logic                            saturated;
    } t_roots;

    typedef struct packed {
        logic               vld;
        t_case              cse;
        logic               an;
        logic               bn;
        logic               cn;
        logic               az;
        logic               bz;
        logic [C_MAG_W-1:0] am;
        logic [C_MAG_W-1:0] bm;
        logic [C_MAG_W-1:0] cm;
        logic               dneg;
        logic               dsmall;
        logic [C_NUM_W-1:0] val;
    } t_side;

    function automatic logic [C_MAG_W-1:0] f_mag(input logic [C_COEFF_WIDTH-1:0] v);
        return v[C_COEFF_WIDTH-1] ? C_MAG_W'(-v) : C_MAG_W'(v);
    endfunction

    // returns {saturated, value}
    function automatic logic [C_COEFF_WIDTH:0] f_clip(input logic neg,
                                                      input logic [C_NUM_W-1:0] mag);
        logic [C_NUM_W-1:0]       lim;
        logic [C_COEFF_WIDTH-1:0] m;
        logic                     s;
        lim = C_NUM_W'(1) << (C_COEFF_WIDTH - 1);
        if (!neg) lim = lim - C_NUM_W'(1);
        s = mag > lim;
        m = s ? C_COEFF_WIDTH'(lim) : C_COEFF_WIDTH'(mag);
        return {s, neg ? -m : m};
    endfunction

endpackage

// ----- hdl/quadratic_root_solver_top.sv -----
// top level of the quadratic root solver: front stages, cell chains, result stage
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------
//  input     | start / busy       | i_coeff (t_coeffs)
//  result    | o_done strobe      | o_roots (t_roots)
//  config    | i_cfg_we           | i_cfg_wdata (epsilon)
//
// one item per cycle while busy is low; items pass through the first divider chain,
// the square root chain and the second divider chains in turn
// busy is high only in reset and the cycle after it; there is no clearing pass
// each result shows for one cycle on o_done; the receiver cannot stall
module quadratic_root_solver_top import qrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_coeffs                i_coeff,
    input  logic                   i_cfg_we,
    input  logic [C_EPS_WIDTH-1:0] i_cfg_wdata,
    output logic                   o_done,
    output t_roots                 o_roots
);

    logic                   r_busy;
    logic [C_EPS_WIDTH-1:0] r_eps;
    t_side                  n_s0;

    t_side              r_sa [C_NUM_W+1];
    logic [C_NUM_W-1:0] w_d1_nq  [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_d1_rem [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_d1_dvs [C_NUM_W+1];

    t_side               r_sm;
    logic [C_PROD_W-1:0] r_bb;
    logic [C_PROD_W-1:0] r_ac;
    logic [C_PROD_W-1:0] w_bb;
    logic [C_PROD_W-1:0] w_ac;

    logic [C_PROD_X_W-1:0] w_bbx;
    logic [C_PROD_X_W-1:0] w_ac4;
    logic [C_PROD_X_W-1:0] w_sum;
    logic [C_PROD_X_W-1:0] w_dif;
    logic [C_D_W-1:0]      w_d;
    logic [C_D_W-1:0]      r_d;
    t_side                 n_sd;

    t_side                 r_sb [C_SQ_N+1];
    logic [C_SQ_RAD_W-1:0] w_sq_rad  [C_SQ_N+1];
    logic [C_SQ_REM_W-1:0] w_sq_rem  [C_SQ_N+1];
    logic [C_SQ_N-1:0]     w_sq_root [C_SQ_N+1];

    t_side              r_sc [C_NUM_W+1];
    logic [C_DVS_W-1:0] r_m;
    t_side              n_sq;
    logic [C_NUM_W-1:0] w_da_nq  [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_da_rem [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_da_dvs [C_NUM_W+1];
    logic [C_NUM_W-1:0] w_db_nq  [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_db_rem [C_NUM_W+1];
    logic [C_DVS_W-1:0] w_db_dvs [C_NUM_W+1];

    t_side                    w_sl;
    logic [C_COEFF_WIDTH:0]   w_clip_a;
    logic [C_COEFF_WIDTH:0]   w_clip_b;
    logic [C_COEFF_WIDTH:0]   w_clip_p;
    logic [C_COEFF_WIDTH:0]   w_clip_n;
    t_roots                   n_out;
    t_roots                   r_out;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_eps  <= C_EPS_WIDTH'(1);
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) r_eps <= i_cfg_wdata;
        end
    end

    assign busy = r_busy;

    // input stage
    always_comb begin
        n_s0     = '0;
        n_s0.vld = start && !r_busy;
        n_s0.an  = i_coeff.coeff_a[C_COEFF_WIDTH-1];
        n_s0.bn  = i_coeff.coeff_b[C_COEFF_WIDTH-1];
        n_s0.cn  = i_coeff.coeff_c[C_COEFF_WIDTH-1];
        n_s0.am  = f_mag(i_coeff.coeff_a);
        n_s0.bm  = f_mag(i_coeff.coeff_b);
        n_s0.cm  = f_mag(i_coeff.coeff_c);
        n_s0.az  = n_s0.am == '0;
        n_s0.bz  = n_s0.bm == '0;
        if (n_s0.cm == '0) n_s0.cse = CASE_C0;
        else if (n_s0.bz)  n_s0.cse = CASE_B0;
        else               n_s0.cse = CASE_GEN;
    end

    always_ff @(posedge i_clk) begin
        r_sa[0] <= n_s0;
        if (!i_rst_n) r_sa[0].vld <= 1'b0;
    end

    // c / a scaled for the b-zero case
    assign w_d1_nq[0]  = C_NUM_W'(r_sa[0].cm) << (2 * C_FRAC_BITS);
    assign w_d1_rem[0] = '0;
    assign w_d1_dvs[0] = C_DVS_W'(r_sa[0].am);

    for (genvar i = 0; i < C_NUM_W; i++) begin : g_div1
        qrs_div_cell u_cell (
            .i_clk (i_clk),
            .i_nq  (w_d1_nq[i]),
            .i_rem (w_d1_rem[i]),
            .i_dvs (w_d1_dvs[i]),
            .o_nq  (w_d1_nq[i+1]),
            .o_rem (w_d1_rem[i+1]),
            .o_dvs (w_d1_dvs[i+1])
        );
        always_ff @(posedge i_clk) begin
            r_sa[i+1] <= r_sa[i];
            if (!i_rst_n) r_sa[i+1].vld <= 1'b0;
        end
    end

    // products
    assign w_bb = r_sa[C_NUM_W].bm * r_sa[C_NUM_W].bm;
    assign w_ac = r_sa[C_NUM_W].am * r_sa[C_NUM_W].cm;

    always_ff @(posedge i_clk) begin
        r_sm     <= r_sa[C_NUM_W];
        r_sm.val <= w_d1_nq[C_NUM_W];
        r_bb     <= w_bb;
        r_ac     <= w_ac;
        if (!i_rst_n) r_sm.vld <= 1'b0;
    end

    // discriminant
    assign w_bbx = C_PROD_X_W'(r_bb);
    assign w_ac4 = {r_ac, 2'b00};
    assign w_sum = w_bbx + w_ac4;
    assign w_dif = w_bbx - w_ac4;
    assign w_d   = (r_sm.an != r_sm.cn) ? C_D_W'(w_sum) : C_D_W'(w_dif);

    always_comb begin
        n_sd        = r_sm;
        n_sd.dneg   = (r_sm.an == r_sm.cn) && (w_bbx < w_ac4);
        n_sd.dsmall = C_CMP_W'(w_d) < C_CMP_W'(r_eps);
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_sd;
        r_d     <= w_d;
        if (!i_rst_n) r_sb[0].vld <= 1'b0;
    end

    assign w_sq_rad[0]  = (r_sb[0].cse == CASE_B0) ? C_SQ_RAD_W'(r_sb[0].val)
                                                    : C_SQ_RAD_W'(r_d);
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    for (genvar i = 0; i < C_SQ_N; i++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rad  (w_sq_rad[i]),
            .i_rem  (w_sq_rem[i]),
            .i_root (w_sq_root[i]),
            .o_rad  (w_sq_rad[i+1]),
            .o_rem  (w_sq_rem[i+1]),
            .o_root (w_sq_root[i+1])
        );
        always_ff @(posedge i_clk) begin
            r_sb[i+1] <= r_sb[i];
            if (!i_rst_n) r_sb[i+1].vld <= 1'b0;
        end
    end

    // b + sqrt(d)
    always_comb begin
        n_sq     = r_sb[C_SQ_N];
        n_sq.val = C_NUM_W'(w_sq_root[C_SQ_N]);
    end

    always_ff @(posedge i_clk) begin
        r_sc[0] <= n_sq;
        r_m     <= C_DVS_W'(r_sb[C_SQ_N].bm) + C_DVS_W'(w_sq_root[C_SQ_N]);
        if (!i_rst_n) r_sc[0].vld <= 1'b0;
    end

    assign w_da_nq[0]  = (r_sc[0].cse == CASE_C0) ? C_NUM_W'(r_sc[0].bm) << C_FRAC_BITS
                                                   : C_NUM_W'(r_m) << C_FRAC_BITS;
    assign w_da_rem[0] = '0;
    assign w_da_dvs[0] = (r_sc[0].cse == CASE_C0) ? C_DVS_W'(r_sc[0].am)
                                                   : C_DVS_W'(r_sc[0].am) << 1;
    assign w_db_nq[0]  = C_NUM_W'(r_sc[0].cm) << (C_FRAC_BITS + 1);
    assign w_db_rem[0] = '0;
    assign w_db_dvs[0] = r_m;

    for (genvar i = 0; i < C_NUM_W; i++) begin : g_div2
        qrs_div_cell u_cell_a (
            .i_clk (i_clk),
            .i_nq  (w_da_nq[i]),
            .i_rem (w_da_rem[i]),
            .i_dvs (w_da_dvs[i]),
            .o_nq  (w_da_nq[i+1]),
            .o_rem (w_da_rem[i+1]),
            .o_dvs (w_da_dvs[i+1])
        );
        qrs_div_cell u_cell_b (
            .i_clk (i_clk),
            .i_nq  (w_db_nq[i]),
            .i_rem (w_db_rem[i]),
            .i_dvs (w_db_dvs[i]),
            .o_nq  (w_db_nq[i+1]),
            .o_rem (w_db_rem[i+1]),
            .o_dvs (w_db_dvs[i+1])
        );
        always_ff @(posedge i_clk) begin
            r_sc[i+1] <= r_sc[i];
            if (!i_rst_n) r_sc[i+1].vld <= 1'b0;
        end
    end

    // result stage
    assign w_sl     = r_sc[C_NUM_W];
    assign w_clip_a = f_clip(!w_sl.bn ^ w_sl.an, w_da_nq[C_NUM_W]);
    assign w_clip_b = f_clip(!w_sl.bn ^ w_sl.cn, w_db_nq[C_NUM_W]);
    assign w_clip_p = f_clip(1'b0, w_sl.val);
    assign w_clip_n = f_clip(1'b1, w_sl.val);

    always_comb begin
        n_out               = '0;
        n_out.root_one_kind = KIND_NAN;
        n_out.root_two_kind = KIND_NAN;
        case (w_sl.cse)
            CASE_C0: begin
                n_out.root_one_kind = KIND_FIN;
                if (!w_sl.bz) begin
                    if (w_sl.az) begin
                        n_out.root_two_kind = w_sl.bn ? KIND_PINF : KIND_MINF;
                    end else begin
                        n_out.root_two      = w_clip_a[C_COEFF_WIDTH-1:0];
                        n_out.root_two_kind = KIND_FIN;
                        n_out.saturated     = w_clip_a[C_COEFF_WIDTH];
                    end
                end
            end
            CASE_B0: begin
                if (w_sl.az) begin
                    n_out.root_one_kind = KIND_PINF;
                end else if (w_sl.an != w_sl.cn) begin
                    n_out.root_one      = w_clip_p[C_COEFF_WIDTH-1:0];
                    n_out.root_two      = w_clip_n[C_COEFF_WIDTH-1:0];
                    n_out.root_one_kind = KIND_FIN;
                    n_out.root_two_kind = KIND_FIN;
                    n_out.saturated     = w_clip_p[C_COEFF_WIDTH] | w_clip_n[C_COEFF_WIDTH];
                end
            end
            CASE_GEN: begin
                if (!w_sl.dneg) begin
                    if (w_sl.az) begin
                        n_out.root_one_kind = w_sl.bn ? KIND_PINF : KIND_MINF;
                    end else begin
                        n_out.root_one      = w_clip_a[C_COEFF_WIDTH-1:0];
                        n_out.root_one_kind = KIND_FIN;
                        n_out.saturated     = w_clip_a[C_COEFF_WIDTH];
                    end
                    if (!w_sl.dsmall) begin
                        n_out.root_two      = w_clip_b[C_COEFF_WIDTH-1:0];
                        n_out.root_two_kind = KIND_FIN;
                        n_out.saturated     = n_out.saturated | w_clip_b[C_COEFF_WIDTH];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= w_sl.vld;
    end

    assign o_done  = r_done;
    assign o_roots = r_out;

endmodule

// ----- hdl/qrs_div_cell.sv -----
// one restoring division step: one quotient bit per cell
module qrs_div_cell import qrs_pkg::*; (
    input  logic               i_clk,
    input  logic [C_NUM_W-1:0] i_nq,
    input  logic [C_DVS_W-1:0] i_rem,
    input  logic [C_DVS_W-1:0] i_dvs,
    output logic [C_NUM_W-1:0] o_nq,
    output logic [C_DVS_W-1:0] o_rem,
    output logic [C_DVS_W-1:0] o_dvs
);

    logic [C_NUM_W-1:0]   r_nq;
    logic [C_DVS_W-1:0]   r_rem;
    logic [C_DVS_W-1:0]   r_dvs;
    logic [C_DIV_T_W-1:0] w_t;
    logic [C_DIV_T_W-1:0] w_dx;
    logic                 w_ge;

    assign w_t  = {i_rem, i_nq[C_NUM_W-1]};
    assign w_dx = {1'b0, i_dvs};
    assign w_ge = w_t >= w_dx;

    always_ff @(posedge i_clk) begin
        r_nq  <= {i_nq[C_NUM_W-2:0], w_ge};
        r_rem <= w_ge ? C_DVS_W'(w_t - w_dx) : C_DVS_W'(w_t);
        r_dvs <= i_dvs;
    end

    assign o_nq  = r_nq;
    assign o_rem = r_rem;
    assign o_dvs = r_dvs;

endmodule

// ----- hdl/qrs_sqrt_cell.sv -----
// one digit step of the floored square root: two radicand bits per cell
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic                  i_clk,
    input  logic [C_SQ_RAD_W-1:0] i_rad,
    input  logic [C_SQ_REM_W-1:0] i_rem,
    input  logic [C_SQ_N-1:0]     i_root,
    output logic [C_SQ_RAD_W-1:0] o_rad,
    output logic [C_SQ_REM_W-1:0] o_rem,
    output logic [C_SQ_N-1:0]     o_root
);

    logic [C_SQ_RAD_W-1:0] r_rad;
    logic [C_SQ_REM_W-1:0] r_rem;
    logic [C_SQ_N-1:0]     r_root;
    logic [C_SQ_T_W-1:0]   w_t;
    logic [C_SQ_T_W-1:0]   w_trial;
    logic                  w_ge;

    assign w_t     = {i_rem, i_rad[C_SQ_RAD_W-1 -: 2]};
    assign w_trial = C_SQ_T_W'({i_root, 2'b01});
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        r_rad  <= {i_rad[C_SQ_RAD_W-3:0], 2'b00};
        r_rem  <= w_ge ? C_SQ_REM_W'(w_t - w_trial) : C_SQ_REM_W'(w_t);
        r_root <= {i_root[C_SQ_N-2:0], w_ge};
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ----- hdl/qrs_checker.sv -----
// port-level checks of the quadratic root solver and their binding
`include "quadratic_root_solver_top_assert.svh"

module qrs_checker import qrs_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   busy,
    input logic   o_done,
    input t_roots o_roots
);

    `QRS_ASSERT_NXT(a_reset_quiet, !i_rst_n, !o_done && busy, "item or ready seen after reset")
    `QRS_ASSERT_IMP(a_one_zero, o_done && o_roots.root_one_kind != KIND_FIN, o_roots.root_one == '0, "non-finite root one carries a value")
    `QRS_ASSERT_IMP(a_two_zero, o_done && o_roots.root_two_kind != KIND_FIN, o_roots.root_two == '0, "non-finite root two carries a value")
    `QRS_ASSERT_IMP(a_sat_fin, o_done && o_roots.saturated, o_roots.root_one_kind == KIND_FIN || o_roots.root_two_kind == KIND_FIN, "saturation without a finite root")

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);

// ----- tb/quadratic_root_solver_top_test.sv -----
// testbench for the quadratic root solver: directed and random equations against a predictor
module quadratic_root_solver_top_test;
    import qrs_pkg::*;

    localparam int LATENCY = 2 * C_NUM_W + C_SQ_N + 5;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_coeffs                i_coeff;
    logic                   i_cfg_we;
    logic [C_EPS_WIDTH-1:0] i_cfg_wdata;
    logic                   o_done;
    t_roots                 o_roots;

    logic [C_EPS_WIDTH-1:0] eps_model;
    t_roots                 roots_due[$];
    bit                     failed;

    quadratic_root_solver_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_coeff     (i_coeff),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_roots     (o_roots)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] magnitude(input logic [31:0] v);
        return {32'd0, v[31] ? 32'(-v) : v};
    endfunction

    function automatic logic [31:0] clip_root(input bit neg, input logic [127:0] mag,
                                              inout bit sat);
        logic [127:0] lim;
        logic [31:0]  m;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = mag[31:0];
        if (mag > lim) begin
            m = lim[31:0];
            sat = 1'b1;
        end
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0]  res;
        logic [63:0]  cand;
        res = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= x) res = cand;
        end
        return res;
    endfunction

    function automatic t_roots solve_roots(input t_coeffs co);
        t_roots       r;
        bit           an, bn, cn, sat, dneg, numneg;
        logic [63:0]  am, bm, cm, m;
        logic [127:0] q, bb, ac4, d;
        an = co.coeff_a[31];
        bn = co.coeff_b[31];
        cn = co.coeff_c[31];
        am = magnitude(co.coeff_a);
        bm = magnitude(co.coeff_b);
        cm = magnitude(co.coeff_c);
        sat = 0;
        r.root_one = 0;
        r.root_two = 0;
        r.root_one_kind = KIND_NAN;
        r.root_two_kind = KIND_NAN;
        if (cm == 0) begin
            r.root_one_kind = KIND_FIN;
            if (bm != 0) begin
                if (am == 0) begin
                    r.root_two_kind = bn ? KIND_PINF : KIND_MINF;
                end else begin
                    q = ({64'd0, bm} << 16) / am;
                    r.root_two = clip_root((!bn) != an, q, sat);
                    r.root_two_kind = KIND_FIN;
                end
            end
        end else if (bm == 0) begin
            if (am == 0) begin
                r.root_one_kind = KIND_PINF;
            end else if (an != cn) begin
                q = ({64'd0, cm} << 32) / am;
                q = {64'd0, isqrt(q)};
                r.root_one = clip_root(0, q, sat);
                r.root_two = clip_root(1, q, sat);
                r.root_one_kind = KIND_FIN;
                r.root_two_kind = KIND_FIN;
            end
        end else begin
            bb = {64'd0, bm} * bm;
            ac4 = ({64'd0, am} * cm) << 2;
            dneg = 0;
            d = 0;
            if (an != cn) d = bb + ac4;
            else if (bb < ac4) dneg = 1;
            else d = bb - ac4;
            if (!dneg) begin
                m = bm + isqrt(d);
                numneg = !bn;
                if (am == 0) begin
                    r.root_one_kind = numneg ? KIND_MINF : KIND_PINF;
                end else begin
                    q = ({64'd0, m} << 16) / (2 * am);
                    r.root_one = clip_root(numneg != an, q, sat);
                    r.root_one_kind = KIND_FIN;
                end
                if (!(d < {80'd0, eps_model})) begin
                    q = ({64'd0, 2 * cm} << 16) / m;
                    r.root_two = clip_root(cn != numneg, q, sat);
                    r.root_two_kind = KIND_FIN;
                end
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n != 0) start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // start stays high after an item so the next one can follow at once
    task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c);
        t_coeffs co;
        co.coeff_a = a;
        co.coeff_b = b;
        co.coeff_c = c;
        i_coeff <= co;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        roots_due.push_back(solve_roots(co));
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (roots_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_epsilon(input logic [C_EPS_WIDTH-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        eps_model = v;
    endtask

    function automatic logic [31:0] random_coeff();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 1023)) - 512);
            1: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_special_cases();
        send_equation(32'h0001_0000, 32'h0002_0000, 32'd0);
        send_equation(32'h0001_0000, 32'd0, 32'd0);
        send_equation(32'd0, 32'h0003_0000, 32'd0);
        send_equation(32'd0, 32'hfffd_0000, 32'd0);
        send_equation(32'h0001_0000, 32'd0, 32'hfffc_0000);
        send_equation(32'h0001_0000, 32'd0, 32'h0004_0000);
        send_equation(32'd0, 32'd0, 32'h0001_0000);
        send_equation(32'd0, 32'h0001_0000, 32'h0002_0000);
        send_equation(32'd0, 32'hffff_0000, 32'h0002_0000);
        send_equation(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_equation(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_equation(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
        send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_equation(32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff);
        send_equation(32'h0000_0001, 32'd0, 32'h8000_0000);
        send_equation(32'h0000_0001, 32'h8000_0000, 32'd0);
        send_equation(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
        send_equation(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
    endtask

    task automatic test_epsilon_settings();
        write_epsilon('0);
        send_equation(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_equation(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
        write_epsilon({C_EPS_WIDTH{1'b1}});
        send_equation(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
        send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        write_epsilon(48'h1_0000_0000);
        send_equation(32'h0001_0000, 32'h0002_0000, 32'hffff_ffff);
        send_equation(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    endtask

    task automatic test_random_equations(input int count);
        logic [31:0] a, b, c;
        for (int i = 0; i < count; i++) begin
            a = random_coeff();
            b = random_coeff();
            c = random_coeff();
            case ($urandom_range(0, 9))
                0: c = 0;
                1: b = 0;
                2: a = 0;
                default: ;
            endcase
            send_equation(a, b, c);
            pause_random();
        end
    endtask

    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_done) begin
            if (roots_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_roots);
                failed = 1;
            end else begin
                want = roots_due.pop_front();
                if (o_roots.root_one !== want.root_one
                    || o_roots.root_one_kind !== want.root_one_kind
                    || o_roots.root_two !== want.root_two
                    || o_roots.root_two_kind !== want.root_two_kind
                    || o_roots.saturated !== want.saturated) begin
                    $display("%0t: mismatch expected %h %0d %h %0d %b actual %h %0d %h %0d %b",
                             $time, want.root_one, want.root_one_kind, want.root_two,
                             want.root_two_kind, want.saturated, o_roots.root_one,
                             o_roots.root_one_kind, o_roots.root_two,
                             o_roots.root_two_kind, o_roots.saturated);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** quadratic_root_solver_top: FAILED **");
        $finish;
    end

    initial begin
        failed = 0;
        eps_model = 1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_coeff = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_special_cases();
        test_random_equations(200);
        drain();
        test_epsilon_settings();
        test_random_equations(200);
        write_epsilon(48'd1);
        test_random_equations(250);
        drain();
        if (roots_due.size() != 0) failed = 1;
        if (!failed) begin
            $display("** quadratic_root_solver_top: PASSED **");
        end else begin
            $display("** quadratic_root_solver_top: FAILED **");
        end
        $finish;
    end

endmodule
